/* hdl/hfe_pkg.sv */
// Package for the Hermite function evaluator: shared constants, coefficient tables,
// controller state and command types, and rounding helpers. No dependencies.
package hfe_pkg;

  localparam int unsigned ORDER_W       = 6;
  localparam int unsigned POS_W         = 16;
  localparam int unsigned VALUE_W       = 17;
  localparam int unsigned MAX_ORDER_DEF = 32;
  localparam int unsigned TAB_DEPTH     = 1 << ORDER_W;
  localparam int unsigned TAYLOR_TERMS  = 13;
  localparam int unsigned TERM_W        = 4;

  localparam logic [32:0] INV_PI_Q30     = 33'd806514912;
  localparam logic [29:0] HALF_LOG2E_Q30 = 30'd774541002;
  localparam logic [29:0] LN2_Q30        = 30'd744261118;
  localparam int          NORM_BIAS      = 44;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 17'sd65535;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = -17'sd65536;

  typedef logic [30:0] coef_tab_t [TAB_DEPTH];
  typedef logic [32:0] rcp_tab_t [16];

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_STEP_MUL, ST_STEP_NORM, ST_GAUSS_Y, ST_GAUSS_U,
    ST_TAY_MUL, ST_TAY_RCP, ST_TAY_UPD, ST_FIN_MUL, ST_FIN_SHIFT, ST_RESULT
  } state_e;

  typedef struct packed {
    logic               load;
    logic               init;
    logic               step_mul;
    logic               step_norm;
    logic               gauss_y;
    logic               gauss_u;
    logic               tay_mul;
    logic               tay_rcp;
    logic               tay_upd;
    logic               fin_mul;
    logic               fin_shift;
    logic               out_load;
    logic [ORDER_W-1:0] k;
    logic [TERM_W-1:0]  j;
  } cmd_t;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic               too_large;
  } status_t;

  // Restoring division, used only while building constant tables.
  function automatic logic [63:0] udiv_const(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] isqrt_const(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'd1 << 62;
    rem  = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic coef_tab_t build_a_tab();
    coef_tab_t t;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      t[k] = 31'(isqrt_const(udiv_const(64'd1 << 61, 64'(k + 1))));
    end
    return t;
  endfunction

  function automatic coef_tab_t build_b_tab();
    coef_tab_t t;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      t[k] = 31'(isqrt_const((64'd1 << 60) - udiv_const(64'd1 << 60, 64'(k + 1))));
    end
    return t;
  endfunction

  function automatic rcp_tab_t build_rcp_tab();
    rcp_tab_t t;
    t[0] = '0;
    for (int k = 1; k < 16; k++) begin
      t[k] = 33'(udiv_const(64'd1 << 32, 64'(k)));
    end
    return t;
  endfunction

  localparam coef_tab_t A_TAB   = build_a_tab();
  localparam coef_tab_t B_TAB   = build_b_tab();
  localparam rcp_tab_t  RCP_TAB = build_rcp_tab();

  // Arithmetic right shift that rounds half away from zero.
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input logic [5:0] s);
    logic [63:0] mag;
    logic [63:0] half;
    if (s == 6'd0) begin
      return v;
    end
    mag  = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    half = 64'd1 << (s - 6'd1);
    mag  = (mag + half) >> s;
    return v[63] ? $signed(64'd0 - mag) : $signed(mag);
  endfunction

endpackage

/* hdl/hfe_datapath.sv */
// Datapath of the Hermite function evaluator: recurrence, Gaussian factor and output.
// Depends on hfe_pkg; driven by commands from hfe_ctrl.
module hfe_datapath #(
  parameter int unsigned MAX_ORDER = hfe_pkg::MAX_ORDER_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hfe_pkg::cmd_t                       cmd_i,
  output hfe_pkg::status_t                    status_o,
  input  logic                                action_i,
  input  logic [hfe_pkg::ORDER_W-1:0]         order_i,
  input  logic signed [hfe_pkg::POS_W-1:0]    position_i,
  output logic signed [hfe_pkg::VALUE_W-1:0]  value_o,
  output logic                                order_too_large_o
);

  logic                              action_q;
  logic [hfe_pkg::ORDER_W-1:0]       order_q;
  logic signed [hfe_pkg::POS_W-1:0]  x_q;
  logic                              too_large_q;
  logic signed [30:0] t_q;
  logic signed [32:0] cur_q, prev_q;
  logic [7:0]         exp_q;
  logic signed [38:0] pa_q;
  logic signed [33:0] pb_q;
  logic [30:0]        xx_q;
  logic [8:0]         yi_q;
  logic [29:0]        f_q;
  logic [29:0]        u_q;
  logic [30:0]        term_q;
  logic signed [31:0] sum_q;
  logic [30:0]        p_q;
  logic [30:0]        qe_q;
  logic signed [63:0] prod_q;
  logic signed [10:0] shift_q;
  logic signed [hfe_pkg::VALUE_W-1:0] psi_q;
  logic signed [hfe_pkg::VALUE_W-1:0] value_q;
  logic                               flag_q;

  logic [hfe_pkg::ORDER_W-1:0] k_next;
  logic signed [47:0] ax;
  logic signed [63:0] tc;
  logic signed [64:0] bp;
  logic signed [39:0] nxt;
  logic [39:0]        mag_n, mag_c, big;
  logic [3:0]         s_norm;
  logic [60:0]        yv;
  logic [38:0]        y39;
  logic [59:0]        fu;
  logic [61:0]        tu;
  logic [63:0]        pr;
  logic [34:0]        qj;
  logic [30:0]        rem;
  logic [30:0]        q_fix;
  logic signed [64:0] cg;
  logic signed [63:0] rs;
  logic signed [hfe_pkg::VALUE_W-1:0] psi_new;
  logic signed [33:0] sq;
  logic [33:0]        sq_r;
  logic signed [hfe_pkg::VALUE_W-1:0] out_val;

  assign status_o.order     = order_q;
  assign status_o.too_large = too_large_q;

  always_comb begin
    k_next = cmd_i.init ? '0 : cmd_i.k + 1'b1;
    ax = $signed({1'b0, hfe_pkg::A_TAB[k_next]}) * x_q;
    tc = t_q * cur_q;
    bp = $signed({1'b0, hfe_pkg::B_TAB[cmd_i.k]}) * prev_q;

    nxt   = 40'(pa_q) - 40'(pb_q);
    mag_n = nxt[39] ? 40'd0 - 40'(nxt) : 40'(nxt);
    mag_c = cur_q[32] ? 40'd0 - 40'(cur_q) : 40'(cur_q);
    big   = (mag_n > mag_c) ? mag_n : mag_c;
    s_norm = '0;
    for (int i = 31; i < 40; i++) begin
      if (big[i]) s_norm = 4'(i - 30);
    end

    yv  = 61'(xx_q) * 61'(hfe_pkg::HALF_LOG2E_Q30);
    y39 = 39'((yv + (61'd1 << 21)) >> 22);
    fu  = 60'(f_q) * 60'(hfe_pkg::LN2_Q30);
    tu  = 62'(term_q) * 62'(u_q);
    pr  = 64'(p_q) * 64'(hfe_pkg::RCP_TAB[cmd_i.j]);
    qj  = 35'(qe_q) * 35'(cmd_i.j);
    rem = p_q - qj[30:0];
    q_fix = (rem >= 31'(cmd_i.j)) ? qe_q + 31'd1 : qe_q;
    cg  = cur_q * sum_q;

    rs = hfe_pkg::rshr(prod_q, shift_q[5:0]);
    if (shift_q >= 11'sd63) begin
      psi_new = '0;
    end else if (shift_q <= 11'sd0) begin
      if (prod_q == 64'sd0) psi_new = '0;
      else if (prod_q > 64'sd0) psi_new = hfe_pkg::VALUE_MAX;
      else psi_new = hfe_pkg::VALUE_MIN;
    end else if (rs > 64'(hfe_pkg::VALUE_MAX)) begin
      psi_new = hfe_pkg::VALUE_MAX;
    end else if (rs < 64'(hfe_pkg::VALUE_MIN)) begin
      psi_new = hfe_pkg::VALUE_MIN;
    end else begin
      psi_new = rs[hfe_pkg::VALUE_W-1:0];
    end

    sq   = psi_q * psi_q;
    sq_r = (34'(sq) + 34'd32768) >> 16;
    if (too_large_q) begin
      out_val = '0;
    end else if (action_q) begin
      out_val = (sq_r > 34'd65535) ? hfe_pkg::VALUE_MAX : $signed(sq_r[16:0]);
    end else begin
      out_val = psi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q    <= action_i;
      order_q     <= order_i;
      x_q         <= position_i;
      too_large_q <= (32'(order_i) > MAX_ORDER);
    end
    if (cmd_i.init) begin
      t_q    <= 31'(hfe_pkg::rshr(64'(ax), 6'd17));
      xx_q   <= 31'($unsigned(32'(x_q * x_q)));
      cur_q  <= $signed(hfe_pkg::INV_PI_Q30);
      prev_q <= '0;
      exp_q  <= '0;
    end
    if (cmd_i.step_mul) begin
      t_q  <= 31'(hfe_pkg::rshr(64'(ax), 6'd17));
      pa_q <= 39'(hfe_pkg::rshr(tc, 6'd24));
      pb_q <= 34'(hfe_pkg::rshr(bp[63:0], 6'd30));
    end
    if (cmd_i.step_norm) begin
      prev_q <= 33'(hfe_pkg::rshr(64'(cur_q), 6'(s_norm)));
      cur_q  <= 33'(hfe_pkg::rshr(64'(nxt), 6'(s_norm)));
      exp_q  <= exp_q + 8'(s_norm);
    end
    if (cmd_i.gauss_y) begin
      yi_q <= y39[38:30];
      f_q  <= y39[29:0];
    end
    if (cmd_i.gauss_u) begin
      u_q    <= 30'((fu + (60'd1 << 29)) >> 30);
      term_q <= 31'd1 << 30;
      sum_q  <= 32'sd1 <<< 30;
    end
    if (cmd_i.tay_mul) begin
      p_q <= 31'((tu + (62'd1 << 29)) >> 30);
    end
    if (cmd_i.tay_rcp) begin
      qe_q <= pr[62:32];
    end
    if (cmd_i.tay_upd) begin
      term_q <= q_fix;
      sum_q  <= cmd_i.j[0] ? sum_q - $signed({1'b0, q_fix})
                           : sum_q + $signed({1'b0, q_fix});
    end
    if (cmd_i.fin_mul) begin
      prod_q  <= cg[63:0];
      shift_q <= 11'(hfe_pkg::NORM_BIAS) + $signed({2'b0, yi_q}) - $signed({3'b0, exp_q});
    end
    if (cmd_i.fin_shift) begin
      psi_q <= psi_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      flag_q  <= 1'b0;
    end else if (cmd_i.out_load) begin
      value_q <= out_val;
      flag_q  <= too_large_q;
    end
  end

  assign value_o           = value_q;
  assign order_too_large_o = flag_q;

endmodule

/* hdl/hfe_ctrl.sv */
// Controller of the Hermite function evaluator: sequences the recurrence, the Gaussian
// series and the output handshake. Depends on hfe_pkg.
module hfe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  hfe_pkg::status_t status_i,
  output hfe_pkg::cmd_t    cmd_o
);

  hfe_pkg::state_e state_q, state_d;
  logic [hfe_pkg::ORDER_W-1:0] k_q, k_d;
  logic [hfe_pkg::TERM_W-1:0]  j_q, j_d;
  logic                        ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hfe_pkg::ST_IDLE;
      k_q     <= '0;
      j_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    j_d        = j_q;
    ov_d       = ov_q && !out_ready_i;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.k    = k_q;
    cmd_o.j    = j_q;
    case (state_q)
      hfe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = hfe_pkg::ST_INIT;
        end
      end
      hfe_pkg::ST_INIT: begin
        cmd_o.init = 1'b1;
        k_d        = '0;
        if (status_i.too_large) state_d = hfe_pkg::ST_RESULT;
        else if (status_i.order == '0) state_d = hfe_pkg::ST_GAUSS_Y;
        else state_d = hfe_pkg::ST_STEP_MUL;
      end
      hfe_pkg::ST_STEP_MUL: begin
        cmd_o.step_mul = 1'b1;
        state_d        = hfe_pkg::ST_STEP_NORM;
      end
      hfe_pkg::ST_STEP_NORM: begin
        cmd_o.step_norm = 1'b1;
        k_d             = k_q + 1'b1;
        state_d = (k_d == status_i.order) ? hfe_pkg::ST_GAUSS_Y : hfe_pkg::ST_STEP_MUL;
      end
      hfe_pkg::ST_GAUSS_Y: begin
        cmd_o.gauss_y = 1'b1;
        state_d       = hfe_pkg::ST_GAUSS_U;
      end
      hfe_pkg::ST_GAUSS_U: begin
        cmd_o.gauss_u = 1'b1;
        j_d           = 4'd1;
        state_d       = hfe_pkg::ST_TAY_MUL;
      end
      hfe_pkg::ST_TAY_MUL: begin
        cmd_o.tay_mul = 1'b1;
        state_d       = hfe_pkg::ST_TAY_RCP;
      end
      hfe_pkg::ST_TAY_RCP: begin
        cmd_o.tay_rcp = 1'b1;
        state_d       = hfe_pkg::ST_TAY_UPD;
      end
      hfe_pkg::ST_TAY_UPD: begin
        cmd_o.tay_upd = 1'b1;
        if (j_q == hfe_pkg::TERM_W'(hfe_pkg::TAYLOR_TERMS)) begin
          state_d = hfe_pkg::ST_FIN_MUL;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = hfe_pkg::ST_TAY_MUL;
        end
      end
      hfe_pkg::ST_FIN_MUL: begin
        cmd_o.fin_mul = 1'b1;
        state_d       = hfe_pkg::ST_FIN_SHIFT;
      end
      hfe_pkg::ST_FIN_SHIFT: begin
        cmd_o.fin_shift = 1'b1;
        state_d         = hfe_pkg::ST_RESULT;
      end
      hfe_pkg::ST_RESULT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ov_d           = 1'b1;
          state_d        = hfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hfe_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = ov_q;

endmodule

/* hdl/hermite_function_evaluator_core.sv */
// Top level of the normalized Hermite function evaluator; instantiates hfe_ctrl and
// hfe_datapath and uses hfe_pkg. Each request gives an order n, a Q4.11 position x and
// an action bit; the block returns psi_n(x) in Q1.16, or its square when action is set.
// Orders above MAX_ORDER return zero with order_too_large raised, without the computation,
// once the output register is free. Otherwise a request is captured and the recurrence
// is seeded, then each recurrence step runs on the shared multiply and normalize unit,
// the Gaussian exponent is formed, each term of the thirteen-term exp series takes a
// multiply, a reciprocal multiply and a correct-and-accumulate step, the final scale and
// shift follow and the output register is loaded.
// A result still waiting in the output register holds the next one back until it is
// taken. One request is in flight at a time and the next can be accepted in the cycle
// after the result is loaded; the output register lets a new request be accepted while
// the previous result still waits.
module hermite_function_evaluator_core #(
  parameter int unsigned MAX_ORDER = hfe_pkg::MAX_ORDER_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [hfe_pkg::ORDER_W-1:0]         order_i,
  input  logic signed [hfe_pkg::POS_W-1:0]    position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [hfe_pkg::VALUE_W-1:0]  value_o,
  output logic                                order_too_large_o
);

  // Commands from the controller to the datapath, status back.
  hfe_pkg::cmd_t    cmd;
  hfe_pkg::status_t status;

  // The controller owns the handshakes and the step counters.
  hfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the request, the recurrence state and the output register.
  hfe_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .action_i          (action_i),
    .order_i           (order_i),
    .position_i        (position_i),
    .value_o           (value_o),
    .order_too_large_o (order_too_large_o)
  );

endmodule

/* tb/hermite_function_evaluator_core_test.sv */
// Testbench for hermite_function_evaluator_core: drives random and directed order/position
// requests and checks value and order_too_large against a bit-accurate psi_n(x) predictor.
// Depends on hfe_pkg for port widths.
`timescale 1ns / 100ps

module hermite_function_evaluator_core_test;

  localparam int unsigned MAX_ORD = 32;
  localparam longint     LIMIT_CYCLES = 1500000;

  typedef struct {
    logic signed [hfe_pkg::VALUE_W-1:0] value;
    logic                               too_large;
  } psi_result_t;

  // Rounds half away from zero on a right shift.
  function automatic longint shr_round(longint v, int s);
    longint m;
    if (s == 0) return v;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Wavefunction value in Q1.16 from the normalized recurrence and the 2^-y Gaussian.
  function automatic longint wavefunction_q16(int n, longint x);
    longint prv, cur, a, b, t, nxt, big, y30, fr, u, sum, term, prod;
    longint unsigned xx;
    int blk_exp, s, sh;
    prv = 0;
    cur = 806514912;
    blk_exp = 0;
    for (int k = 0; k < n; k++) begin
      a = sqrt_floor((64'd1 << 61) / (k + 1));
      b = sqrt_floor((64'd1 << 60) - (64'd1 << 60) / (k + 1));
      t = shr_round(a * x, 17);
      nxt = shr_round(t * cur, 24) - shr_round(b * prv, 30);
      big = (abs64(nxt) > abs64(cur)) ? abs64(nxt) : abs64(cur);
      s = 0;
      while ((big >>> s) >= (64'sd1 <<< 31)) s++;
      prv = shr_round(cur, s);
      cur = shr_round(nxt, s);
      blk_exp += s;
    end
    xx = longint'(x * x);
    y30 = shr_round(longint'(xx * 64'd774541002), 22);
    fr = y30 & ((64'sd1 <<< 30) - 1);
    u = shr_round(fr * 744261118, 30);
    sum = 64'sd1 <<< 30;
    term = 64'sd1 <<< 30;
    for (int k = 1; k <= 13; k++) begin
      term = shr_round(term * u, 30) / k;
      if (k % 2 == 1) sum -= term;
      else sum += term;
    end
    prod = cur * sum;
    sh = 44 + int'(y30 >>> 30) - blk_exp;
    if (sh >= 63) return 0;
    if (sh <= 0) begin
      if (prod == 0) return 0;
      return (prod > 0) ? 65535 : -65536;
    end
    prod = shr_round(prod, sh);
    if (prod > 65535) return 65535;
    if (prod < -65536) return -65536;
    return prod;
  endfunction

  function automatic psi_result_t predict_psi(logic act, logic [hfe_pkg::ORDER_W-1:0] n,
                                              logic signed [hfe_pkg::POS_W-1:0] pos);
    psi_result_t r;
    longint v;
    if (n > MAX_ORD) begin
      r.value = '0;
      r.too_large = 1'b1;
      return r;
    end
    v = wavefunction_q16(int'(n), longint'(pos));
    if (act) begin
      v = shr_round(v * v, 16);
      if (v > 65535) v = 65535;
    end
    r.value = hfe_pkg::VALUE_W'(v);
    r.too_large = 1'b0;
    return r;
  endfunction

  // Holds predicted results in request order and compares each returned result.
  class psi_scoreboard;
    psi_result_t pending[$];
    int errors;
    int checked;

    function void note_request(logic act, logic [hfe_pkg::ORDER_W-1:0] n,
                               logic signed [hfe_pkg::POS_W-1:0] pos);
      pending = {pending, predict_psi(act, n, pos)};
    endfunction

    function void check_result(logic signed [hfe_pkg::VALUE_W-1:0] val, logic tl);
      psi_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%0d order_too_large=%0b", $time, val, tl);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (val !== e.value) begin
        $display("%0t: value mismatch expected %0d actual %0d", $time, e.value, val);
        errors++;
      end
      if (tl !== e.too_large) begin
        $display("%0t: order_too_large mismatch expected %0b actual %0b",
                 $time, e.too_large, tl);
        errors++;
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic                               action;
  logic [hfe_pkg::ORDER_W-1:0]        order;
  logic signed [hfe_pkg::POS_W-1:0]   position;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [hfe_pkg::VALUE_W-1:0] value;
  logic                               order_too_large;

  psi_scoreboard sb;
  int     send_idle_pct;
  int     recv_idle_pct;
  longint cycles;
  int     sent;

  hermite_function_evaluator_core #(.MAX_ORDER(MAX_ORD)) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .order_i          (order),
    .position_i       (position),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .value_o          (value),
    .order_too_large_o(order_too_large)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The receiver stalls at random; results are checked at the accepting edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(value, order_too_large);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL hermite_function_evaluator_core");
      $finish;
    end
  end

  // Presents one request, with an optional random idle gap first, and waits for acceptance.
  // Valid stays high after acceptance until the next idle cycle or a new request.
  task automatic send_request(logic act, logic [hfe_pkg::ORDER_W-1:0] n,
                              logic signed [hfe_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    order    <= n;
    position <= pos;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, n, pos);
    sent++;
  endtask

  // Mostly orders in range with positions where psi is not negligible; some anything.
  task automatic send_random_request();
    logic [hfe_pkg::ORDER_W-1:0] n;
    logic signed [hfe_pkg::POS_W-1:0] pos;
    case ($urandom_range(9))
      0:       n = hfe_pkg::ORDER_W'($urandom_range(63));
      1:       n = hfe_pkg::ORDER_W'($urandom_range(MAX_ORD, MAX_ORD - 3));
      default: n = hfe_pkg::ORDER_W'($urandom_range(MAX_ORD));
    endcase
    if ($urandom_range(3) == 0) pos = hfe_pkg::POS_W'($urandom);
    else pos = hfe_pkg::POS_W'($signed($urandom_range(2 * 9 * 2048)) - 9 * 2048);
    send_request(1'($urandom), n, pos);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    action = 1'b0;
    order = '0;
    position = '0;
    out_ready = 1'b0;
    cycles = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: order zero, top order, orders above the maximum, position extremes.
    send_request(1'b0, 6'd0, 16'sd0);
    send_request(1'b1, 6'd0, 16'sd0);
    send_request(1'b0, 6'd1, 16'sd2048);
    send_request(1'b0, 6'd2, -16'sd2048);
    send_request(1'b0, hfe_pkg::ORDER_W'(MAX_ORD), 16'sd4096);
    send_request(1'b1, hfe_pkg::ORDER_W'(MAX_ORD), -16'sd5000);
    send_request(1'b0, hfe_pkg::ORDER_W'(MAX_ORD + 1), 16'sd100);
    send_request(1'b1, 6'd63, -16'sd1);
    send_request(1'b0, 6'd63, 16'sh7fff);
    send_request(1'b0, 6'd5, 16'sh7fff);
    send_request(1'b1, 6'd5, -16'sh8000);
    send_request(1'b0, 6'd0, -16'sh8000);
    send_request(1'b0, 6'd31, 16'sd1);
    send_request(1'b1, 6'd3, 16'sd3000);
    send_request(1'b0, 6'd10, 16'sd12000);
    send_request(1'b1, 6'd20, -16'sd10000);
    drain();

    // Random phases: receiver idles more, then the sender, then no idling.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 65 : 0;
      recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 31 : 0;
      for (int i = 0; i < 380; i++) begin
        send_random_request();
        // Hold off until everything outstanding has come back.
        if (i == 190) begin
          in_valid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
    end
    drain();

    $display("Sent %0d requests and checked %0d results across all orders,", sent, sb.checked);
    $display("both actions, position extremes and three idling mixes.");
    if (sb.errors == 0) begin
      $display("PASS hermite_function_evaluator_core");
    end else begin
      $display("FAIL hermite_function_evaluator_core");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/hfe_pkg.sv
hdl/hfe_datapath.sv
hdl/hfe_ctrl.sv
hdl/hermite_function_evaluator_core.sv
tb/hermite_function_evaluator_core_test.sv
